[hw/rtl/egcd_pkg.sv]
// ----------------------------------------------------------------------------
// egcd_pkg: shared constants and types of the gcd block
// Default operand width, queue depth and the status bundle that the
// operand queue hands to its neighbours.
// ----------------------------------------------------------------------------
`default_nettype none

package egcd_pkg;

  // Default operand width in bits.
  localparam int OPERAND_BITS_DEF = 31;

  // Entries in the queue between the front and the back end.
  localparam int QUEUE_DEPTH_DEF = 2;

  // Queue status as seen by the front end (full) and the back end (empty).
  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage : egcd_pkg

`default_nettype wire

[hw/rtl/egcd_if.sv]
// ----------------------------------------------------------------------------
// egcd_if: valid/ready channels of the gcd block
// Operand channel and result channel, each with a source and a sink side.
// ----------------------------------------------------------------------------
`default_nettype none

interface egcd_in_if #(
  parameter int OPERAND_BITS = egcd_pkg::OPERAND_BITS_DEF
);
  logic                    valid;
  logic                    ready;
  logic [OPERAND_BITS-1:0] first_operand;
  logic [OPERAND_BITS-1:0] second_operand;

  modport source (output valid, output first_operand, output second_operand, input ready);
  modport sink   (input valid, input first_operand, input second_operand, output ready);
endinterface : egcd_in_if

interface egcd_out_if #(
  parameter int OPERAND_BITS = egcd_pkg::OPERAND_BITS_DEF
);
  logic                    valid;
  logic                    ready;
  logic [OPERAND_BITS-1:0] divisor_result;
  logic                    undefined_flag;

  modport source (output valid, output divisor_result, output undefined_flag, input ready);
  modport sink   (input valid, input divisor_result, input undefined_flag, output ready);
endinterface : egcd_out_if

`default_nettype wire

[hw/rtl/egcd_front.sv]
// ----------------------------------------------------------------------------
// egcd_front: operand intake and classification
// Takes operand transfers while the queue has room and marks pairs with a
// zero operand, whose gcd is undefined, so the back end can skip them.
// ----------------------------------------------------------------------------
`default_nettype none

module egcd_front #(
  parameter int OPERAND_BITS = egcd_pkg::OPERAND_BITS_DEF
) (
  egcd_in_if.sink                   in_ch,
  input  egcd_pkg::q_status_t       q_stat,
  output logic                      push,
  output logic [2*OPERAND_BITS:0]   push_data
);
  import egcd_pkg::*;

  logic undef;

  assign in_ch.ready = !q_stat.full;
  assign push        = in_ch.valid && !q_stat.full;
  assign undef       = (in_ch.first_operand == '0) || (in_ch.second_operand == '0);
  assign push_data   = {undef, in_ch.first_operand, in_ch.second_operand};

endmodule : egcd_front

`default_nettype wire

[hw/rtl/egcd_queue.sv]
// ----------------------------------------------------------------------------
// egcd_queue: short operand queue
// Small first-in first-out store that decouples intake from computation.
// ----------------------------------------------------------------------------
`default_nettype none

module egcd_queue #(
  parameter int DATA_BITS = 2 * egcd_pkg::OPERAND_BITS_DEF + 1,
  parameter int DEPTH     = egcd_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  logic [DATA_BITS-1:0] push_data,
  input  logic                 pop,
  output logic [DATA_BITS-1:0] pop_data,
  output egcd_pkg::q_status_t  q_stat
);
  import egcd_pkg::*;

  localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_BITS = $clog2(DEPTH + 1);
  localparam logic [PTR_BITS-1:0] LAST = PTR_BITS'(DEPTH - 1);

  logic [DATA_BITS-1:0] mem_r [DEPTH];
  logic [PTR_BITS-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PTR_BITS-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CNT_BITS-1:0]  count_r, count_nxt;

  assign q_stat.full  = (count_r == CNT_BITS'(DEPTH));
  assign q_stat.empty = (count_r == '0);
  assign pop_data     = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (!q_stat.full || pop))
    else $error("queue written while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !q_stat.empty)
    else $error("queue read while empty");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_BITS'(DEPTH))
    else $error("queue count beyond depth");

endmodule : egcd_queue

`default_nettype wire

[hw/rtl/egcd_back.sv]
// ----------------------------------------------------------------------------
// egcd_back: iterative gcd engine
// Binary gcd: one halve or subtract-and-halve step a cycle, with the common
// factors of two counted and restored by a shift at the end.
// ----------------------------------------------------------------------------
`default_nettype none

module egcd_back #(
  parameter int OPERAND_BITS = egcd_pkg::OPERAND_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  egcd_pkg::q_status_t     q_stat,
  input  logic [2*OPERAND_BITS:0] pop_data,
  output logic                    pop,
  egcd_out_if.source              out_ch
);
  import egcd_pkg::*;

  localparam int W  = OPERAND_BITS;
  localparam int KW = $clog2(W + 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_HOLD
  } state_t;

  state_t         state_r;
  logic [W-1:0]   a_r, a_nxt;
  logic [W-1:0]   b_r, b_nxt;
  logic [KW-1:0]  k_r, k_nxt;
  logic [W-1:0]   res_r;
  logic           undef_r;
  logic           done;
  logic [W-1:0]   diff;
  logic           q_undef;
  logic [W-1:0]   q_a;
  logic [W-1:0]   q_b;

  assign {q_undef, q_a, q_b} = pop_data;
  assign pop = (state_r == ST_IDLE) && !q_stat.empty;

  assign out_ch.valid          = (state_r == ST_HOLD);
  assign out_ch.divisor_result = res_r;
  assign out_ch.undefined_flag = undef_r;

  // One binary gcd step; both values stay non-zero throughout.
  always_comb begin
    a_nxt = a_r;
    b_nxt = b_r;
    k_nxt = k_r;
    done  = 1'b0;
    diff  = (a_r > b_r) ? (a_r - b_r) : (b_r - a_r);
    priority if (a_r == b_r) begin
      done = 1'b1;
    end else if (!a_r[0] && !b_r[0]) begin
      a_nxt = a_r >> 1;
      b_nxt = b_r >> 1;
      k_nxt = k_r + 1'b1;
    end else if (!a_r[0]) begin
      a_nxt = a_r >> 1;
    end else if (!b_r[0]) begin
      b_nxt = b_r >> 1;
    end else if (a_r > b_r) begin
      a_nxt = diff >> 1;
    end else begin
      b_nxt = diff >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      unique case (state_r)
        ST_IDLE: begin
          if (!q_stat.empty) begin
            a_r <= q_a;
            b_r <= q_b;
            k_r <= '0;
            if (q_undef) begin
              res_r   <= '0;
              undef_r <= 1'b1;
              state_r <= ST_HOLD;
            end else begin
              state_r <= ST_RUN;
            end
          end
        end
        ST_RUN: begin
          a_r <= a_nxt;
          b_r <= b_nxt;
          k_r <= k_nxt;
          if (done) begin
            res_r   <= W'(a_r << k_r);
            undef_r <= 1'b0;
            state_r <= ST_HOLD;
          end
        end
        ST_HOLD: begin
          if (out_ch.ready) begin
            state_r <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  a_run_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RUN) |-> (a_r != '0) && (b_r != '0))
    else $error("gcd engine running on a zero value");

  a_undef_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.undefined_flag) |-> (out_ch.divisor_result == '0))
    else $error("undefined result carries a non-zero gcd");

  a_def_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && !out_ch.undefined_flag) |-> (out_ch.divisor_result != '0))
    else $error("defined result carries a zero gcd");

  a_shift_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RUN) |-> (k_r < KW'(W)))
    else $error("factor-of-two count out of range");

endmodule : egcd_back

`default_nettype wire

[hw/rtl/euclid_gcd.sv]
// ----------------------------------------------------------------------------
// euclid_gcd: greatest common divisor of two unsigned operands
//
// Operands arrive on in_ch (valid/ready), one pair per transfer; each pair
// gives exactly one result transfer on out_ch, in order. When either
// operand is zero the result has undefined_flag set and a gcd of zero.
// The front end takes a pair whenever the two-entry operand queue has room,
// so up to two pairs can be taken while the engine is busy or its result
// waits. The back end computes the gcd by the binary method: one halving or
// subtract-and-halve step per cycle on the iteration registers, then a
// final shift that restores the common powers of two.
// A pair with a zero operand skips the iteration: the engine reads it from the
// queue and goes straight to the held result. Any other pair is stepped until
// the two values are equal, then shifted and handed over. The engine takes no
// new pair from the queue until the result of the last one has been taken.
// Reset (rst_n low, synchronous) empties the queue and idles the engine.
// A stalled receiver holds the result on out_ch; the engine waits and the
// queue fills, after which in_ch.ready drops.
// ----------------------------------------------------------------------------
`default_nettype none

module euclid_gcd #(
  parameter int OPERAND_BITS = egcd_pkg::OPERAND_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  egcd_in_if.sink    in_ch,
  egcd_out_if.source out_ch
);
  import egcd_pkg::*;

  localparam int ENTRY_BITS = 2 * OPERAND_BITS + 1;

  // Queue entry: undefined mark, first operand, second operand.
  logic                  push;
  logic [ENTRY_BITS-1:0] push_data;
  logic                  pop;
  logic [ENTRY_BITS-1:0] pop_data;
  q_status_t             q_stat;

  egcd_front #(
    .OPERAND_BITS(OPERAND_BITS)
  ) u_front (
    .in_ch    (in_ch),
    .q_stat   (q_stat),
    .push     (push),
    .push_data(push_data)
  );

  egcd_queue #(
    .DATA_BITS(ENTRY_BITS),
    .DEPTH    (QUEUE_DEPTH_DEF)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_data(push_data),
    .pop      (pop),
    .pop_data (pop_data),
    .q_stat   (q_stat)
  );

  egcd_back #(
    .OPERAND_BITS(OPERAND_BITS)
  ) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_stat  (q_stat),
    .pop_data(pop_data),
    .pop     (pop),
    .out_ch  (out_ch)
  );

endmodule : euclid_gcd

`default_nettype wire
